FILE: hw/rtl/rmpb_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmpb_pkg
// Shared constants, types and the page transpose for the row-major to
// column-page bitmap converter.
// -----------------------------------------------------------------------------
package rmpb_pkg;

    // Frame geometry
    localparam int LINE_PIXELS  = 160;
    localparam int BAND_COUNT   = 6;
    localparam int HEADER_BYTES = 32;

    localparam int MAX_RESULTS  = 32;
    localparam int GROUPS       = LINE_PIXELS / 8;
    localparam int STORED_ROWS  = 7;
    localparam int PAGE_BYTES   = 8;
    localparam int LAST_ROW     = 7;

    // Header length, clipped to one result burst and at least one byte
    localparam int HDR_LEN = (HEADER_BYTES > MAX_RESULTS) ? MAX_RESULTS :
                             (HEADER_BYTES < 1) ? 1 : HEADER_BYTES;

    localparam logic [7:0] REPORT_ID = 8'h03;

    localparam int GROUP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int BAND_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    localparam int ROW_W   = 3;
    localparam int IDX_W   = $clog2(MAX_RESULTS);

    // Job queue between the input stage and the result emitter
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = JOB_PTR_W + 1;

    typedef enum logic
    {
        JOB_HEADER = 1'b0,
        JOB_PAGE   = 1'b1
    } job_kind_t;

    typedef logic [STORED_ROWS-1:0][7:0] band_word_t;
    typedef logic [PAGE_BYTES-1:0][7:0]  page_t;

    typedef struct packed
    {
        job_kind_t kind;
        logic      frame_last;
        page_t     page;
    } job_t;

    // Transpose: byte b covers column b of the group (leftmost first),
    // bit k is band row k; row 7 comes from the incoming byte.
    function automatic page_t build_page(input band_word_t rows, input logic [7:0] px);
        page_t pg;
        for (int b = 0; b < PAGE_BYTES; b++)
        begin
            for (int k = 0; k < STORED_ROWS; k++)
            begin
                pg[b][k] = rows[k][7-b];
            end
            pg[b][7] = px[7-b];
        end
        return pg;
    endfunction

endpackage

FILE: hw/rtl/rmpb_band_store.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmpb_band_store
// Holds rows 0..6 of the current band, one word of seven bytes per column
// group, written one byte lane at a time, read as a whole word.
// -----------------------------------------------------------------------------
module rmpb_band_store
    import rmpb_pkg::*;
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [GROUP_W-1:0] wr_group,
    input  logic [ROW_W-1:0]   wr_row,
    input  logic [7:0]         wr_byte,
    input  logic               rd_en,
    input  logic [GROUP_W-1:0] rd_group,
    output band_word_t         rd_word
);

    band_word_t mem [GROUPS];
    band_word_t rd_word_reg;

    // Write one row lane of a group word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_group][wr_row] <= wr_byte;
        end
    end

    // Registered word read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_group];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

FILE: hw/rtl/rmpb_job_fifo.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmpb_job_fifo
// Small queue of header and page jobs waiting for the result emitter.
// -----------------------------------------------------------------------------
module rmpb_job_fifo
    import rmpb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  job_t                 push_job,
    input  logic                 pop,
    output job_t                 head_job,
    output logic                 head_valid,
    output logic [JOB_CNT_W-1:0] count
);

    job_t                 fifo_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg;
    logic [JOB_PTR_W-1:0] wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg;
    logic [JOB_PTR_W-1:0] rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg;
    logic [JOB_CNT_W-1:0] count_next;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold job payloads
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job   = fifo_mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

FILE: hw/rtl/rmpb_emitter.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmpb_emitter
// Walks the head job one result per cycle into the output register while m_tready does not stall it.
// -----------------------------------------------------------------------------
module rmpb_emitter
    import rmpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head_job,
    input  logic       head_valid,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] lcd_byte
    output logic       m_tlast,
    output logic       m_tuser     // [0] frame_end
);

    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic [7:0]       m_tdata_next;
    logic             m_tlast_reg;
    logic             m_tlast_next;
    logic             m_tuser_reg;
    logic             m_tuser_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             load;
    logic             is_last;
    logic [7:0]       cur_byte;

    // Select the current result of the head job
    always_comb
    begin
        case (head_job.kind)
            JOB_HEADER:
            begin
                cur_byte = (idx_reg == '0) ? REPORT_ID : 8'h00;
                is_last  = (idx_reg == IDX_W'(HDR_LEN - 1));
            end
            JOB_PAGE:
            begin
                cur_byte = head_job.page[idx_reg[2:0]];
                is_last  = (idx_reg == IDX_W'(PAGE_BYTES - 1));
            end
            default:
            begin
                cur_byte = 8'h00;
                is_last  = 1'b1;
            end
        endcase
    end

    // Load the output register when it is empty or being taken
    always_comb
    begin
        load          = !m_tvalid_reg || m_tready;
        pop           = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        idx_next      = idx_reg;
        if (load)
        begin
            m_tvalid_next = head_valid;
            if (head_valid)
            begin
                m_tdata_next = cur_byte;
                m_tlast_next = is_last;
                m_tuser_next = is_last && (head_job.kind == JOB_PAGE) && head_job.frame_last;
                if (is_last)
                begin
                    idx_next = '0;
                    pop      = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            idx_reg      <= idx_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hw/rtl/row_major_to_page_bitmap.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// row_major_to_page_bitmap
// Turns a row-major 1 bpp frame into column-page bytes, with a header burst
// at the start of every frame.
//
//   channel | dir | tdata           | tlast       | tuser
//   s_*     | in  | [7:0] pixel_byte| -           | -
//   m_*     | out | [7:0] lcd_byte  | last_of_run | [0] frame_end
//
// An item of rows 0..6 yields nothing unless it starts a frame. A row-7 item
// yields 8 results and a frame-start item HDR_LEN results, one per cycle from
// the single output register unless m_tready stalls it; a 4-deep job queue
// lets input run ahead of the output until the queue is full. An accepted
// item passes the capture registers and the job queue to the output register.
// Reset clears counters, queue and output valid; the band store needs none.
// A stall on m_tready holds the output and backs up into the queue.
// -----------------------------------------------------------------------------
module row_major_to_page_bitmap
    import rmpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] pixel_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] lcd_byte
    output logic       m_tlast,    // last_of_run
    output logic       m_tuser     // [0] frame_end
);

    logic [GROUP_W-1:0]   group_reg;
    logic [GROUP_W-1:0]   group_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [BAND_W-1:0]    band_reg;
    logic [BAND_W-1:0]    band_next;

    logic                 s1_valid_reg;
    logic [7:0]           s1_byte_reg;
    logic                 s1_header_reg;
    logic                 s1_page_reg;
    logic                 s1_frame_last_reg;

    logic                 accept;
    band_word_t           rd_word;
    job_t                 push_job;
    logic                 push;
    job_t                 head_job;
    logic                 head_valid;
    logic                 pop;
    logic [JOB_CNT_W-1:0] job_count;

    // Leave room in the queue for the item already in flight
    assign s_tready = (job_count + JOB_CNT_W'(s1_valid_reg)) < JOB_CNT_W'(JOB_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Advance group, row and band position
    always_comb
    begin
        group_next = group_reg;
        row_next   = row_reg;
        band_next  = band_reg;
        if (accept)
        begin
            if (group_reg == GROUP_W'(GROUPS - 1))
            begin
                group_next = '0;
                row_next   = row_reg + 1'b1;
                if (row_reg == ROW_W'(LAST_ROW))
                begin
                    band_next = (band_reg == BAND_W'(BAND_COUNT - 1)) ? '0 : band_reg + 1'b1;
                end
            end
            else
            begin
                group_next = group_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg    <= '0;
            row_reg      <= '0;
            band_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            group_reg    <= group_next;
            row_reg      <= row_next;
            band_reg     <= band_next;
            s1_valid_reg <= accept;
        end
    end

    // Capture the item and what its position means
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg       <= s_tdata;
            s1_header_reg     <= (band_reg == '0) && (row_reg == '0) && (group_reg == '0);
            s1_page_reg       <= (row_reg == ROW_W'(LAST_ROW));
            s1_frame_last_reg <= (band_reg == BAND_W'(BAND_COUNT - 1)) &&
                                 (group_reg == GROUP_W'(GROUPS - 1));
        end
    end

    rmpb_band_store u_store
    (
        .clk      (clk),
        .wr_en    (accept && (row_reg != ROW_W'(LAST_ROW))),
        .wr_group (group_reg),
        .wr_row   (row_reg),
        .wr_byte  (s_tdata),
        .rd_en    (accept),
        .rd_group (group_reg),
        .rd_word  (rd_word)
    );

    // Form the job: header burst or transposed page
    always_comb
    begin
        push_job.kind       = s1_header_reg ? JOB_HEADER : JOB_PAGE;
        push_job.frame_last = s1_frame_last_reg;
        push_job.page       = build_page(rd_word, s1_byte_reg);
    end

    assign push = s1_valid_reg && (s1_header_reg || s1_page_reg);

    rmpb_job_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_job   (head_job),
        .head_valid (head_valid),
        .count      (job_count)
    );

    rmpb_emitter u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: hw/rtl/rmpb_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rmpb_checker
// Port-level checks on the bitmap converter, bound to the top level.
// -----------------------------------------------------------------------------
module rmpb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // Frame end only closes a run
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_end without last_of_run");

    // No result straight out of reset
    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !m_tvalid)
        else $error("result right after reset");

    // Hold an offered input item until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("offered input item changed before it was taken");

endmodule

bind row_major_to_page_bitmap rmpb_checker u_rmpb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
